// ===== src/krs_pkg.sv =====
// ----------------------------------------------------------------------------
// krs_pkg
// Types, codes and constants shared by the kick release scheduler files.
// ----------------------------------------------------------------------------
package krs_pkg;

  localparam int TICKS_PER_MS_DEF = 100;
  localparam int TICK_W = 7;
  localparam int MS_W = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_KICK = 2'd1;
  localparam logic [1:0] ACT_FORCED = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_REJECTED = 3'd1;
  localparam logic [2:0] EV_EXPIRED = 3'd2;
  localparam logic [2:0] EV_TOO_SOON = 3'd3;
  localparam logic [2:0] EV_FIRED = 3'd4;
  localparam logic [2:0] EV_DONE = 3'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_VOLT_CEILING = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_WINDOW = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_TOLERANCE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPIRE_MS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GAP_MS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOOST_AFTER_KICK = 3'd5;

  localparam logic [7:0] VOLT_CEILING_RST = 8'd0;
  localparam logic [7:0] VOLTAGE_WINDOW_RST = 8'd10;
  localparam logic [7:0] VOLTAGE_TOLERANCE_RST = 8'd0;
  localparam logic [15:0] EXPIRE_MS_RST = 16'd2000;
  localparam logic [15:0] MIN_GAP_MS_RST = 16'd200;
  localparam logic BOOST_AFTER_KICK_RST = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [15:0] release_ticks;
    logic [7:0] force_voltage;
    logic [7:0] cap_voltage;
    logic booster_ready;
  } krs_item_t;

  typedef struct packed {
    logic release_res;
    logic booster_hold;
    logic booster_resume;
    logic [2:0] event_res;
  } krs_result_t;

  typedef struct packed {
    logic [7:0] volt_ceiling;
    logic [7:0] voltage_window;
    logic [7:0] voltage_tolerance;
    logic [15:0] expire_ms;
    logic [15:0] min_gap_ms;
    logic boost_after_kick;
  } krs_cfg_t;

  typedef struct packed {
    logic releasing;
    logic job_valid;
    logic pulse_nonzero;
  } krs_status_t;

endpackage

// ===== src/krs_if.sv =====
// ----------------------------------------------------------------------------
// krs_if
// Valid/ready channels for the scheduler's requests and results.
// ----------------------------------------------------------------------------
interface krs_item_if;
  import krs_pkg::*;

  logic valid;
  logic ready;
  krs_item_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface krs_result_if;
  import krs_pkg::*;

  logic valid;
  logic ready;
  krs_result_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== src/krs_cfg.sv =====
// ----------------------------------------------------------------------------
// krs_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module krs_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [krs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [krs_pkg::CFG_DATA_W-1:0] cfg_data,
  output krs_pkg::krs_cfg_t cfg
);
  import krs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volt_ceiling <= VOLT_CEILING_RST;
      cfg.voltage_window <= VOLTAGE_WINDOW_RST;
      cfg.voltage_tolerance <= VOLTAGE_TOLERANCE_RST;
      cfg.expire_ms <= EXPIRE_MS_RST;
      cfg.min_gap_ms <= MIN_GAP_MS_RST;
      cfg.boost_after_kick <= BOOST_AFTER_KICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOLT_CEILING: cfg.volt_ceiling <= cfg_data[7:0];
        CFG_VOLTAGE_WINDOW: cfg.voltage_window <= cfg_data[7:0];
        CFG_VOLTAGE_TOLERANCE: cfg.voltage_tolerance <= cfg_data[7:0];
        CFG_EXPIRE_MS: cfg.expire_ms <= cfg_data;
        CFG_MIN_GAP_MS: cfg.min_gap_ms <= cfg_data;
        CFG_BOOST_AFTER_KICK: cfg.boost_after_kick <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/krs_core.sv =====
// ----------------------------------------------------------------------------
// krs_core
// Millisecond clock, pending kick job and release pulse state; handles one
// registered request per cycle while step is high and forms its result.
// ----------------------------------------------------------------------------
module krs_core #(
  parameter int TICKS_PER_MS = krs_pkg::TICKS_PER_MS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  krs_pkg::krs_item_t item,
  input  krs_pkg::krs_cfg_t cfg,
  output krs_pkg::krs_result_t result,
  output krs_pkg::krs_status_t status
);
  import krs_pkg::*;

  logic [MS_W-1:0] ms_clock, ms_clock_next;
  logic [TICK_W-1:0] tick_in_ms, tick_in_ms_next;
  logic job_valid, job_valid_next;
  logic [MS_W-1:0] job_time, job_time_next;
  logic [MS_W-1:0] last_kick_time, last_kick_time_next;
  logic [15:0] pulse_length, pulse_length_next;
  logic [7:0] wanted_voltage, wanted_voltage_next;
  logic [15:0] pulse_left, pulse_left_next;
  logic releasing, releasing_next;

  logic [TICK_W-1:0] tick_inc;
  logic [MS_W-1:0] gap, age;
  logic [7:0] volt_diff, window_low;
  logic [15:0] pulse_dec;
  logic resume;
  logic [2:0] event_code;

  always_comb begin
    ms_clock_next = ms_clock;
    tick_in_ms_next = tick_in_ms;
    job_valid_next = job_valid;
    job_time_next = job_time;
    last_kick_time_next = last_kick_time;
    pulse_length_next = pulse_length;
    wanted_voltage_next = wanted_voltage;
    pulse_left_next = pulse_left;
    releasing_next = releasing;
    resume = 1'b0;
    event_code = EV_NONE;

    tick_inc = tick_in_ms + TICK_W'(1);
    if (tick_inc >= TICK_W'(TICKS_PER_MS)) begin
      tick_inc = '0;
    end
    gap = '0;
    age = '0;
    volt_diff = (wanted_voltage > item.cap_voltage) ? wanted_voltage - item.cap_voltage
                                                    : item.cap_voltage - wanted_voltage;
    window_low = (cfg.voltage_window > cfg.volt_ceiling) ? 8'd0
                                                         : cfg.volt_ceiling - cfg.voltage_window;
    pulse_dec = pulse_left - 16'd1;

    if (item.action == ACT_TICK) begin
      tick_in_ms_next = tick_inc;
      if (tick_inc == '0) begin
        ms_clock_next = ms_clock + MS_W'(1);
      end
      gap = ms_clock_next - last_kick_time;
      age = ms_clock_next - job_time;
      if (releasing) begin
        pulse_left_next = pulse_dec;
        if (pulse_dec == '0) begin
          releasing_next = 1'b0;
          resume = cfg.boost_after_kick;
          event_code = EV_DONE;
          job_valid_next = 1'b0;
          last_kick_time_next = ms_clock_next;
        end
      end else if (job_valid) begin
        if (gap < MS_W'(cfg.min_gap_ms)) begin
          job_valid_next = 1'b0;
          event_code = EV_TOO_SOON;
        end else if (wanted_voltage == '0 || volt_diff <= cfg.voltage_tolerance) begin
          wanted_voltage_next = '0;
          if (age > MS_W'(cfg.expire_ms)) begin
            job_valid_next = 1'b0;
            event_code = EV_EXPIRED;
          end else if (item.booster_ready) begin
            releasing_next = 1'b1;
            pulse_left_next = (pulse_length == '0) ? 16'd1 : pulse_length;
            event_code = EV_FIRED;
          end
        end
      end
    end else if ((item.action == ACT_KICK || item.action == ACT_FORCED) && !releasing) begin
      if (item.action == ACT_FORCED &&
          (item.force_voltage > cfg.volt_ceiling || item.force_voltage < window_low)) begin
        event_code = EV_REJECTED;
      end else begin
        job_valid_next = 1'b1;
        job_time_next = ms_clock;
        pulse_length_next = item.release_ticks;
        wanted_voltage_next = (item.action == ACT_FORCED) ? item.force_voltage : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_clock <= '0;
      tick_in_ms <= '0;
      job_valid <= 1'b0;
      job_time <= '0;
      last_kick_time <= '0;
      pulse_length <= '0;
      wanted_voltage <= '0;
      pulse_left <= '0;
      releasing <= 1'b0;
    end else if (step) begin
      ms_clock <= ms_clock_next;
      tick_in_ms <= tick_in_ms_next;
      job_valid <= job_valid_next;
      job_time <= job_time_next;
      last_kick_time <= last_kick_time_next;
      pulse_length <= pulse_length_next;
      wanted_voltage <= wanted_voltage_next;
      pulse_left <= pulse_left_next;
      releasing <= releasing_next;
    end
  end

  always_comb begin
    result.release_res = releasing_next;
    result.booster_hold = releasing_next;
    result.booster_resume = resume;
    result.event_res = event_code;
    status.releasing = releasing;
    status.job_valid = job_valid;
    status.pulse_nonzero = (pulse_left != '0);
  end

endmodule

// ===== src/kick_release_scheduler.sv =====
// ----------------------------------------------------------------------------
// kick_release_scheduler
// Schedules kicker release pulses from 10 us ticks and kick requests.
// ----------------------------------------------------------------------------
// Every request on the item channel yields exactly one result. Requests
// enter an input register and are handled against the scheduler state once
// the output register is free or being drained, with the result going to the
// output register, from which it is offered on the result channel; one
// request is accepted every cycle as long as results are drained. The single
// pass of compare and update logic in krs_core sets that rate. Configuration
// writes are meant for idle periods only.
module kick_release_scheduler #(
  parameter int TICKS_PER_MS = krs_pkg::TICKS_PER_MS_DEF
) (
  input  logic clk,
  input  logic rst,
  krs_item_if.sink item,
  krs_result_if.source result,
  input  logic cfg_we,
  input  logic [krs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [krs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import krs_pkg::*;

  logic in_valid;
  krs_item_t in_data;
  logic out_valid;
  krs_result_t out_data;
  logic step;
  krs_cfg_t cfg;
  krs_result_t core_result;
  krs_status_t status;

  assign step = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || step;
  assign result.valid = out_valid;
  assign result.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_data <= item.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= core_result;
    end
  end

  krs_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  krs_core #(
    .TICKS_PER_MS(TICKS_PER_MS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .step(step),
    .item(in_data),
    .cfg(cfg),
    .result(core_result),
    .status(status)
  );

`ifndef SYNTHESIS
  a_release_has_job: assert property (@(posedge clk) disable iff (rst)
    status.releasing |-> status.job_valid)
    else $error("release pulse running without a job");

  a_release_count_live: assert property (@(posedge clk) disable iff (rst)
    status.releasing |-> status.pulse_nonzero)
    else $error("release pulse running with no ticks left");

  a_done_drops_release: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload.event_res == EV_DONE) |-> !result.payload.release_res)
    else $error("done event while release still driven");

  a_fired_sets_release: assert property (@(posedge clk) disable iff (rst)
    (step && core_result.event_res == EV_FIRED) |=> status.releasing)
    else $error("fired event did not start a release pulse");
`endif

endmodule

// ===== verif/kick_release_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// kick_release_scheduler_test
// Self-checking bench for the kick release scheduler. A clocked driver feeds
// requests from a queue, predicts the coil, booster and event outputs for
// each accepted request and queues them; a clocked monitor stalls results at
// random and compares every field against the oldest prediction. Directed
// cases come first, then random kick sequences under several register sets,
// and last a stretch of random traffic with no idling.
// ----------------------------------------------------------------------------
module kick_release_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import krs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  krs_item_if item_ch();
  krs_result_if result_ch();

  kick_release_scheduler dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  krs_item_t kick_reqs[$];
  krs_result_t coil_event_due[$];
  krs_cfg_t cfg_shadow;

  int unaccepted = 0;
  int items_queued = 0;
  int mismatches = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit calm_tail = 1'b0;

  bit [31:0] ms_now = '0;
  bit [31:0] job_stamp = '0;
  bit [31:0] last_fire_ms = '0;
  bit [6:0] sub_tick = '0;
  bit job_pending = 1'b0;
  bit pulse_on = 1'b0;
  bit [15:0] job_len = '0;
  bit [15:0] ticks_left = '0;
  bit [7:0] job_volts = '0;

  function automatic int window_low();
    if (cfg_shadow.voltage_window > cfg_shadow.volt_ceiling) return 0;
    return int'(cfg_shadow.volt_ceiling) - int'(cfg_shadow.voltage_window);
  endfunction

  function automatic krs_result_t predict_coil_event(krs_item_t it);
    krs_result_t r;
    logic [2:0] ev;
    logic resume;
    logic [7:0] diff;
    bit volts_ok;
    ev = EV_NONE;
    resume = 1'b0;
    if (it.action == ACT_TICK) begin
      sub_tick = sub_tick + 7'd1;
      if (sub_tick >= TICKS_PER_MS_DEF) begin
        sub_tick = '0;
        ms_now = ms_now + 32'd1;
      end
      if (pulse_on) begin
        ticks_left = ticks_left - 16'd1;
        if (ticks_left == 16'd0) begin
          pulse_on = 1'b0;
          resume = cfg_shadow.boost_after_kick;
          ev = EV_DONE;
          job_pending = 1'b0;
          last_fire_ms = ms_now;
        end
      end else if (job_pending) begin
        if (ms_now - last_fire_ms < 32'(cfg_shadow.min_gap_ms)) begin
          job_pending = 1'b0;
          ev = EV_TOO_SOON;
        end else begin
          volts_ok = 1'b1;
          if (job_volts != 8'd0) begin
            diff = (job_volts > it.cap_voltage) ? job_volts - it.cap_voltage
                                                : it.cap_voltage - job_volts;
            if (diff > cfg_shadow.voltage_tolerance) volts_ok = 1'b0;
            else job_volts = 8'd0;
          end
          if (volts_ok) begin
            if (ms_now - job_stamp > 32'(cfg_shadow.expire_ms)) begin
              job_pending = 1'b0;
              ev = EV_EXPIRED;
            end else if (it.booster_ready) begin
              pulse_on = 1'b1;
              ticks_left = (job_len == 16'd0) ? 16'd1 : job_len;
              ev = EV_FIRED;
            end
          end
        end
      end
    end else if ((it.action == ACT_KICK || it.action == ACT_FORCED) && !pulse_on) begin
      if (it.action == ACT_FORCED && (it.force_voltage > cfg_shadow.volt_ceiling ||
          int'(it.force_voltage) < window_low())) begin
        ev = EV_REJECTED;
      end else begin
        job_pending = 1'b1;
        job_stamp = ms_now;
        job_len = it.release_ticks;
        job_volts = (it.action == ACT_FORCED) ? it.force_voltage : 8'd0;
      end
    end
    r.release_res = pulse_on;
    r.booster_hold = pulse_on;
    r.booster_resume = resume;
    r.event_res = ev;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got_v, int want_v);
    mismatches++;
    $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got_v, want_v);
  endtask

  always @(posedge clk) begin : feed_proc
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.payload <= '0;
      gap_left = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        coil_event_due.push_back(predict_coil_event(item_ch.payload));
        unaccepted--;
      end
      if (!(item_ch.valid && !item_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (!calm_tail && kick_reqs.size() != 0 && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 18);
          item_ch.valid <= 1'b0;
        end else if (kick_reqs.size() != 0) begin
          item_ch.payload <= kick_reqs.pop_front();
          item_ch.valid <= 1'b1;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_proc
    krs_result_t got;
    krs_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        if (coil_event_due.size() == 0) begin
          report_mismatch("unexpected result", int'(got), -1);
        end else begin
          want = coil_event_due.pop_front();
          if (got.release_res !== want.release_res)
            report_mismatch("release_res", got.release_res, want.release_res);
          if (got.booster_hold !== want.booster_hold)
            report_mismatch("booster_hold", got.booster_hold, want.booster_hold);
          if (got.booster_resume !== want.booster_resume)
            report_mismatch("booster_resume", got.booster_resume, want.booster_resume);
          if (got.event_res !== want.event_res)
            report_mismatch("event_res", got.event_res, want.event_res);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 18);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void push_item(logic [1:0] act, logic [15:0] len, logic [7:0] force_v,
                                    logic [7:0] cap, logic rdy);
    krs_item_t it;
    it.action = act;
    it.release_ticks = len;
    it.force_voltage = force_v;
    it.cap_voltage = cap;
    it.booster_ready = rdy;
    kick_reqs.push_back(it);
    unaccepted++;
    if (act != ACT_UNUSED) items_queued++;
  endfunction

  function automatic void push_tick(logic [7:0] cap, logic rdy);
    push_item(ACT_TICK, 16'($urandom), 8'($urandom), cap, rdy);
  endfunction

  function automatic void push_kick(logic [15:0] len);
    push_item(ACT_KICK, len, 8'($urandom), 8'($urandom), 1'($urandom));
  endfunction

  function automatic void push_forced(logic [15:0] len, logic [7:0] volts);
    push_item(ACT_FORCED, len, volts, 8'($urandom), 1'($urandom));
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_VOLT_CEILING: cfg_shadow.volt_ceiling = data[7:0];
      CFG_VOLTAGE_WINDOW: cfg_shadow.voltage_window = data[7:0];
      CFG_VOLTAGE_TOLERANCE: cfg_shadow.voltage_tolerance = data[7:0];
      CFG_EXPIRE_MS: cfg_shadow.expire_ms = data;
      CFG_MIN_GAP_MS: cfg_shadow.min_gap_ms = data;
      CFG_BOOST_AFTER_KICK: cfg_shadow.boost_after_kick = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_cfg(logic [7:0] mv, logic [7:0] win, logic [7:0] tol,
                           logic [15:0] exp_ms, logic [15:0] gap_ms, logic boost);
    write_reg(CFG_VOLT_CEILING, 16'(mv));
    write_reg(CFG_VOLTAGE_WINDOW, 16'(win));
    write_reg(CFG_VOLTAGE_TOLERANCE, 16'(tol));
    write_reg(CFG_EXPIRE_MS, exp_ms);
    write_reg(CFG_MIN_GAP_MS, gap_ms);
    write_reg(CFG_BOOST_AFTER_KICK, 16'(boost));
  endtask

  task automatic drain_outputs();
    while (unaccepted != 0 || coil_event_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic random_traffic(int n);
    int start, r, len, v, lo, hi, tol, cap, waits, k;
    bit forced;
    start = items_queued;
    while (items_queued - start < n) begin
      r = $urandom_range(0, 99);
      lo = window_low();
      hi = int'(cfg_shadow.volt_ceiling);
      tol = int'(cfg_shadow.voltage_tolerance);
      if (r < 55) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 400) : $urandom_range(0, 8);
        forced = ($urandom_range(0, 2) != 0);
        v = forced ? $urandom_range(lo, hi) : 0;
        if (forced) push_forced(16'(len), 8'(v));
        else push_kick(16'(len));
        waits = $urandom_range(0, 4);
        for (k = 0; k < waits; k++) push_tick(8'($urandom), 1'($urandom));
        waits = len + 2 + $urandom_range(0, 3);
        for (k = 0; k < waits; k++) begin
          if (forced && $urandom_range(0, 4) != 0) begin
            cap = v + int'($urandom_range(0, 2 * tol + 2)) - (tol + 1);
            if (cap < 0) cap = 0;
            if (cap > 255) cap = 255;
          end else begin
            cap = $urandom_range(0, 255);
          end
          push_tick(8'(cap), $urandom_range(0, 6) != 0);
          if ($urandom_range(0, 29) == 0) push_kick(16'($urandom_range(0, 8)));
        end
      end else if (r < 72) begin
        waits = $urandom_range(1, 30);
        for (k = 0; k < waits; k++) push_tick(8'($urandom), 1'($urandom));
      end else if (r < 82) begin
        if (lo > 0 && (hi == 255 || $urandom_range(0, 1) == 0)) begin
          v = $urandom_range(0, lo - 1);
          len = $urandom_range(0, 65535);
        end else if (hi < 255) begin
          v = $urandom_range(hi + 1, 255);
          len = $urandom_range(0, 65535);
        end else begin
          v = $urandom_range(0, 255);
          len = $urandom_range(0, 8);
        end
        push_forced(16'(len), 8'(v));
      end else if (r < 90) begin
        waits = $urandom_range(100, 250);
        for (k = 0; k < waits; k++) push_tick(8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        k = $urandom_range(0, 3);
        if (k == 1 || k == 2)
          push_item(2'(k), 16'($urandom_range(0, 8)), 8'($urandom), 8'($urandom),
                    1'($urandom));
        else
          push_item(2'(k), 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.payload = '0;
    result_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_shadow.volt_ceiling = VOLT_CEILING_RST;
    cfg_shadow.voltage_window = VOLTAGE_WINDOW_RST;
    cfg_shadow.voltage_tolerance = VOLTAGE_TOLERANCE_RST;
    cfg_shadow.expire_ms = EXPIRE_MS_RST;
    cfg_shadow.min_gap_ms = MIN_GAP_MS_RST;
    cfg_shadow.boost_after_kick = BOOST_AFTER_KICK_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: every job is too soon and only zero volts is in the window.
    push_kick(16'd0);
    push_tick(8'd0, 1'b1);
    push_forced(16'd7, 8'd255);
    push_forced(16'd5, 8'd0);
    push_tick(8'd255, 1'b1);
    push_item(ACT_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    drain_outputs();

    apply_cfg(8'd200, 8'd255, 8'd0, 16'd0, 16'd0, 1'b1);
    push_kick(16'd0);
    push_tick(8'd255, 1'b0);
    push_tick(8'd0, 1'b1);
    push_tick(8'd0, 1'b1);
    push_forced(16'd1, 8'd255);
    push_forced(16'd2, 8'd150);
    push_tick(8'd151, 1'b1);
    push_kick(16'd3);
    push_tick(8'd0, 1'b1);
    push_kick(16'hFFFF);
    push_tick(8'd0, 1'b1);
    push_tick(8'd0, 1'b1);
    push_tick(8'd0, 1'b1);
    push_forced(16'd1, 8'd120);
    push_tick(8'd121, 1'b1);
    push_tick(8'd120, 1'b0);
    push_tick(8'd0, 1'b1);
    push_tick(8'd0, 1'b1);
    drain_outputs();

    apply_cfg(8'd255, 8'd0, 8'd255, 16'd3, 16'd1, 1'b0);
    random_traffic(300);
    drain_outputs();

    apply_cfg(8'($urandom), 8'($urandom), 8'($urandom_range(0, 4)),
              16'($urandom_range(0, 4)), 16'($urandom_range(0, 2)), 1'($urandom));
    random_traffic(300);
    drain_outputs();

    apply_cfg(8'd0, 8'd0, 8'd0, 16'hFFFF, 16'd0, 1'b1);
    random_traffic(250);
    drain_outputs();

    apply_cfg(8'($urandom), 8'($urandom), 8'($urandom_range(0, 4)), 16'd1, 16'hFFFF, 1'b1);
    random_traffic(200);
    drain_outputs();

    apply_cfg(8'($urandom), 8'($urandom_range(0, 40)), 8'($urandom_range(0, 4)),
              16'($urandom_range(1, 4)), 16'($urandom_range(0, 1)), 1'($urandom));
    random_traffic(300);
    drain_outputs();

    apply_cfg(8'($urandom), 8'($urandom), 8'($urandom_range(0, 4)), 16'd5, 16'd0,
              1'($urandom));
    calm_tail = 1'b1;
    random_traffic(250);
    drain_outputs();

    if (coil_event_due.size() != 0)
      report_mismatch("results left outstanding", 0, coil_event_due.size());
    if (mismatches == 0) begin
      $display("kick_release_scheduler_test: done, clean");
    end else begin
      $display("kick_release_scheduler_test: done, errors");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("kick_release_scheduler_test: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/krs_pkg.sv
src/krs_if.sv
src/krs_cfg.sv
src/krs_core.sv
src/kick_release_scheduler.sv
verif/kick_release_scheduler_test.sv
